// ===== rtl/core/pjr_pkg.sv =====
package pjr_pkg;

  // One Q16.16 sample on either channel.
  typedef logic signed [31:0] word_t;

  // Number of Jacobian entries in one result.
  localparam int unsigned NUM_J = 6;

  // Register map, in word order.
  typedef enum logic [2:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_CENTER_Z = 3'd4,
    REG_SCALE_S  = 3'd5
  } reg_idx_t;

endpackage

// ===== rtl/core/pjr_in_if.sv =====
interface pjr_in_if;
  import pjr_pkg::*;

  logic  valid;
  logic  ready;
  word_t point_x;
  word_t point_y;
  word_t point_z;
  word_t grad_x;
  word_t grad_y;

  modport source(output valid, point_x, point_y, point_z, grad_x, grad_y, input ready);
  modport sink(input valid, point_x, point_y, point_z, grad_x, grad_y, output ready);
endinterface

// ===== rtl/core/pjr_out_if.sv =====
interface pjr_out_if;
  import pjr_pkg::*;

  logic  valid;
  logic  ready;
  word_t j_0;
  word_t j_1;
  word_t j_2;
  word_t j_3;
  word_t j_4;
  word_t j_5;
  logic  depth_invalid;

  modport source(output valid, j_0, j_1, j_2, j_3, j_4, j_5, depth_invalid, input ready);
  modport sink(input valid, j_0, j_1, j_2, j_3, j_4, j_5, depth_invalid, output ready);
endinterface

// ===== rtl/core/photometric_jacobian_row.sv =====
// Photometric SE(3) Jacobian row, one point per transaction.
// The input channel carries a 3D point and the image gradient at it, all
// signed Q16.16. The result channel carries the six Jacobian entries, each
// rounded to nearest and saturated to signed Q16.16, plus depth_invalid,
// which is set when the depth is zero (all entries then saturate).
// The APB-style configuration port holds focal lengths, the inverse pose
// translation and the scale; write it only while the pipeline is empty.
// The path from input transaction to result: six stages of multiply and
// add build the exact numerators and denominators, one stage takes
// magnitudes and checks for overflow, six dividers side by side then
// retire one quotient bit per stage over 32 stages, and a last stage rounds
// and saturates. Throughput is one point per cycle while the receiver does not stall.
// Reset clears all valid bits and loads the register reset values.
// When the receiver stalls, the whole pipeline holds and in_ch.ready
// drops; nothing is lost or repeated.
module photometric_jacobian_row (
  input  logic       clk,
  input  logic       rst_n,
  pjr_in_if.sink     in_ch,
  pjr_out_if.source  out_ch,
  input  logic       cfg_psel,
  input  logic       cfg_penable,
  input  logic       cfg_pwrite,
  input  logic [4:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic       cfg_pready
);
  import pjr_pkg::*;

  localparam int unsigned NW  = 100;
  localparam int unsigned DW  = 96;
  localparam int unsigned RW  = 128;
  localparam int unsigned QB  = 32;
  localparam int unsigned NST = 40;

  // Configuration registers.
  logic [30:0] fx_r, fy_r, sc_r;
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_r <= 31'd33554432;
      fy_r <= 31'd33554432;
      cx_r <= '0;
      cy_r <= '0;
      cz_r <= '0;
      sc_r <= 31'd65536;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FOCAL_X:  fx_r <= cfg_pwdata[30:0];
        REG_FOCAL_Y:  fy_r <= cfg_pwdata[30:0];
        REG_CENTER_X: cx_r <= cfg_pwdata;
        REG_CENTER_Y: cy_r <= cfg_pwdata;
        REG_CENTER_Z: cz_r <= cfg_pwdata;
        REG_SCALE_S:  sc_r <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (cfg_idx)
      REG_FOCAL_X:  cfg_prdata = {1'b0, fx_r};
      REG_FOCAL_Y:  cfg_prdata = {1'b0, fy_r};
      REG_CENTER_X: cfg_prdata = cx_r;
      REG_CENTER_Y: cfg_prdata = cy_r;
      REG_CENTER_Z: cfg_prdata = cz_r;
      REG_SCALE_S:  cfg_prdata = {1'b0, sc_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // Pipeline advance: the whole pipe moves unless the output is stalled.
  logic adv;
  logic [NST-1:0] vld_r;

  assign adv         = !vld_r[NST-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_ch.valid};
    end
  end

  // Stage 1: gradient scaling products, differences, depth square.
  logic signed [63:0] up_nxt, vp_nxt, zz_nxt;
  logic signed [32:0] dx_nxt, dy_nxt, dz_nxt;
  logic [31:0] az_nxt;
  logic [30:0] s_nxt;

  assign up_nxt = $signed({1'b0, fx_r}) * in_ch.grad_x;
  assign vp_nxt = $signed({1'b0, fy_r}) * in_ch.grad_y;
  assign zz_nxt = in_ch.point_z * in_ch.point_z;
  assign dx_nxt = 33'(in_ch.point_x) - 33'(cx_r);
  assign dy_nxt = 33'(in_ch.point_y) - 33'(cy_r);
  assign dz_nxt = 33'(in_ch.point_z) - 33'(cz_r);
  assign az_nxt = in_ch.point_z[31] ? (~in_ch.point_z + 32'd1) : in_ch.point_z;
  assign s_nxt  = (sc_r == '0) ? 31'd1 : sc_r;

  logic signed [63:0] s1_up_r, s1_vp_r;
  logic [63:0] s1_zz_r;
  logic signed [32:0] s1_dx_r, s1_dy_r, s1_dz_r;
  logic signed [31:0] s1_x_r, s1_y_r, s1_z_r;
  logic [31:0] s1_az_r;
  logic [30:0] s1_s_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_up_r <= up_nxt;
      s1_vp_r <= vp_nxt;
      s1_zz_r <= zz_nxt;
      s1_dx_r <= dx_nxt;
      s1_dy_r <= dy_nxt;
      s1_dz_r <= dz_nxt;
      s1_x_r  <= in_ch.point_x;
      s1_y_r  <= in_ch.point_y;
      s1_z_r  <= in_ch.point_z;
      s1_az_r <= az_nxt;
      s1_s_r  <= s_nxt;
    end
  end

  // Stage 2: floor to Q16.16 and saturate u and v; |z| times s.
  function automatic logic signed [31:0] sat_floor(input logic signed [63:0] p);
    logic signed [47:0] f;
    begin
      f = 48'(p >>> 16);
      if (f > 48'sh7FFF_FFFF)
        sat_floor = 32'sh7FFF_FFFF;
      else if (f < -48'sh8000_0000)
        sat_floor = 32'sh8000_0000;
      else
        sat_floor = f[31:0];
    end
  endfunction

  logic signed [31:0] s2_u_r, s2_v_r, s2_x_r, s2_y_r, s2_z_r;
  logic [62:0] s2_zs_r;
  logic [63:0] s2_zz_r;
  logic signed [32:0] s2_dx_r, s2_dy_r, s2_dz_r;
  logic [31:0] s2_az_r;
  logic [30:0] s2_s_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_u_r  <= sat_floor(s1_up_r);
      s2_v_r  <= sat_floor(s1_vp_r);
      s2_zs_r <= 63'(s1_az_r) * 63'(s1_s_r);
      s2_zz_r <= s1_zz_r;
      s2_x_r  <= s1_x_r;
      s2_y_r  <= s1_y_r;
      s2_z_r  <= s1_z_r;
      s2_dx_r <= s1_dx_r;
      s2_dy_r <= s1_dy_r;
      s2_dz_r <= s1_dz_r;
      s2_az_r <= s1_az_r;
      s2_s_r  <= s1_s_r;
    end
  end

  // Stage 3: products of u and v with the point, and partial s*z^2.
  logic signed [63:0] a_nxt, b_nxt, vz_nxt, uz_nxt;
  logic signed [64:0] pv_nxt, pu_nxt;

  assign a_nxt  = s2_x_r * s2_u_r;
  assign b_nxt  = s2_y_r * s2_v_r;
  assign vz_nxt = s2_v_r * s2_z_r;
  assign uz_nxt = s2_u_r * s2_z_r;
  assign pv_nxt = 65'(s2_v_r) * 65'(s2_dx_r);
  assign pu_nxt = 65'(s2_u_r) * 65'(s2_dy_r);

  logic signed [63:0] s3_a_r, s3_b_r, s3_vz_r, s3_uz_r;
  logic signed [64:0] s3_pv_r, s3_pu_r;
  logic [62:0] s3_zzh_r, s3_zzl_r, s3_zs_r;
  logic [63:0] s3_zz_r;
  logic signed [31:0] s3_u_r, s3_v_r;
  logic signed [32:0] s3_dx_r, s3_dy_r, s3_dz_r;
  logic [31:0] s3_az_r;
  logic        s3_zn_r, s3_z0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_a_r   <= a_nxt;
      s3_b_r   <= b_nxt;
      s3_vz_r  <= vz_nxt;
      s3_uz_r  <= uz_nxt;
      s3_pv_r  <= pv_nxt;
      s3_pu_r  <= pu_nxt;
      s3_zzh_r <= 63'(s2_zz_r[63:32]) * 63'(s2_s_r);
      s3_zzl_r <= 63'(s2_zz_r[31:0]) * 63'(s2_s_r);
      s3_zs_r  <= s2_zs_r;
      s3_zz_r  <= s2_zz_r;
      s3_u_r   <= s2_u_r;
      s3_v_r   <= s2_v_r;
      s3_dx_r  <= s2_dx_r;
      s3_dy_r  <= s2_dy_r;
      s3_dz_r  <= s2_dz_r;
      s3_az_r  <= s2_az_r;
      s3_zn_r  <= s2_z_r[31];
      s3_z0_r  <= (s2_z_r == '0);
    end
  end

  // Stage 4: g, split products with dz, the third numerator and s*z^2.
  logic signed [64:0] ab_sum;
  logic signed [48:0] g_nxt;

  assign ab_sum = 65'(s3_a_r) + 65'(s3_b_r);
  assign g_nxt  = 49'(ab_sum >>> 16);

  logic signed [48:0] s4_g_r;
  logic signed [64:0] s4_vzh_r, s4_uzh_r;
  logic signed [65:0] s4_vzl_r, s4_uzl_r, s4_n2_r;
  logic [93:0] s4_szz_r;
  logic [62:0] s4_zs_r;
  logic [63:0] s4_zz_r;
  logic signed [31:0] s4_u_r, s4_v_r;
  logic signed [32:0] s4_dx_r, s4_dy_r;
  logic [31:0] s4_az_r;
  logic        s4_zn_r, s4_z0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_g_r   <= g_nxt;
      s4_vzh_r <= 65'($signed(s3_vz_r[63:32])) * 65'(s3_dz_r);
      s4_vzl_r <= 66'($signed({1'b0, s3_vz_r[31:0]})) * 66'(s3_dz_r);
      s4_uzh_r <= 65'($signed(s3_uz_r[63:32])) * 65'(s3_dz_r);
      s4_uzl_r <= 66'($signed({1'b0, s3_uz_r[31:0]})) * 66'(s3_dz_r);
      s4_n2_r  <= 66'(s3_pv_r) - 66'(s3_pu_r);
      s4_szz_r <= (94'(s3_zzh_r) << 32) + 94'(s3_zzl_r);
      s4_zs_r  <= s3_zs_r;
      s4_zz_r  <= s3_zz_r;
      s4_u_r   <= s3_u_r;
      s4_v_r   <= s3_v_r;
      s4_dx_r  <= s3_dx_r;
      s4_dy_r  <= s3_dy_r;
      s4_az_r  <= s3_az_r;
      s4_zn_r  <= s3_zn_r;
      s4_z0_r  <= s3_z0_r;
    end
  end

  // Stage 5: split products of g with dx and dy; join the dz products.
  logic signed [49:0] s5_gdyh_r, s5_gdxh_r;
  logic signed [65:0] s5_gdyl_r, s5_gdxl_r, s5_n2_r;
  logic signed [96:0] s5_vzd_r, s5_uzd_r;
  logic signed [48:0] s5_g_r;
  logic [93:0] s5_szz_r;
  logic [62:0] s5_zs_r;
  logic [63:0] s5_zz_r;
  logic signed [31:0] s5_u_r, s5_v_r;
  logic [31:0] s5_az_r;
  logic        s5_zn_r, s5_z0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_gdyh_r <= 50'($signed(s4_g_r[48:32])) * 50'(s4_dy_r);
      s5_gdyl_r <= 66'($signed({1'b0, s4_g_r[31:0]})) * 66'(s4_dy_r);
      s5_gdxh_r <= 50'($signed(s4_g_r[48:32])) * 50'(s4_dx_r);
      s5_gdxl_r <= 66'($signed({1'b0, s4_g_r[31:0]})) * 66'(s4_dx_r);
      s5_vzd_r  <= (97'(s4_vzh_r) <<< 32) + 97'(s4_vzl_r);
      s5_uzd_r  <= (97'(s4_uzh_r) <<< 32) + 97'(s4_uzl_r);
      s5_n2_r   <= s4_n2_r;
      s5_g_r    <= s4_g_r;
      s5_szz_r  <= s4_szz_r;
      s5_zs_r   <= s4_zs_r;
      s5_zz_r   <= s4_zz_r;
      s5_u_r    <= s4_u_r;
      s5_v_r    <= s4_v_r;
      s5_az_r   <= s4_az_r;
      s5_zn_r   <= s4_zn_r;
      s5_z0_r   <= s4_z0_r;
    end
  end

  // Stage 6: exact signed numerators and unsigned denominators.
  logic signed [81:0] gdy, gdx;
  logic signed [NW-1:0] n0, n1, n2, n3, n4, n5;
  logic signed [NW-1:0] num_nxt [NUM_J];
  logic [DW-1:0] den_nxt [NUM_J];

  assign gdy = (82'(s5_gdyh_r) <<< 32) + 82'(s5_gdyl_r);
  assign gdx = (82'(s5_gdxh_r) <<< 32) + 82'(s5_gdxl_r);
  assign n0  = NW'(s5_vzd_r) + (NW'(gdy) <<< 16);
  assign n1  = NW'(s5_uzd_r) + (NW'(gdx) <<< 16);
  assign n2  = NW'(s5_n2_r);
  assign n3  = NW'(s5_u_r) <<< 32;
  assign n4  = NW'(s5_v_r) <<< 32;
  assign n5  = NW'(s5_g_r) <<< 48;

  always_comb begin
    num_nxt[0] = -n0;
    num_nxt[1] = n1;
    num_nxt[2] = s5_zn_r ? -n2 : n2;
    num_nxt[3] = s5_zn_r ? -n3 : n3;
    num_nxt[4] = s5_zn_r ? -n4 : n4;
    num_nxt[5] = -n5;
    den_nxt[0] = DW'(s5_zz_r);
    den_nxt[1] = DW'(s5_zz_r);
    den_nxt[2] = DW'(s5_az_r);
    den_nxt[3] = DW'(s5_zs_r);
    den_nxt[4] = DW'(s5_zs_r);
    den_nxt[5] = DW'(s5_szz_r);
  end

  logic signed [NW-1:0] s6_num_r [NUM_J];
  logic [DW-1:0] s6_den_r [NUM_J];
  logic          s6_z0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < NUM_J; l++) begin
        s6_num_r[l] <= num_nxt[l];
        s6_den_r[l] <= den_nxt[l];
      end
      s6_z0_r <= s5_z0_r;
    end
  end

  // Divider stages: index 0 holds magnitude and overflow check, then one
  // quotient bit per stage from bit 31 down to bit 0.
  logic [RW-1:0] rem_r [QB+1][NUM_J];
  logic [QB-1:0] q_r   [QB+1][NUM_J];
  logic [DW-1:0] dn_r  [QB+1][NUM_J];
  logic          neg_r [QB+1][NUM_J];
  logic          ovf_r [QB+1][NUM_J];
  logic          z0_r  [QB+1];

  logic [NW-1:0] mag [NUM_J];
  logic [RW-1:0] trial [QB+1][NUM_J];
  logic          take  [QB+1][NUM_J];

  // Each stage compares the previous stage's remainder with that same
  // transaction's shifted divisor.
  always_comb begin
    for (int l = 0; l < NUM_J; l++) begin
      mag[l] = s6_num_r[l][NW-1] ? NW'(-s6_num_r[l]) : NW'(s6_num_r[l]);
    end
    for (int k = 0; k <= QB; k++) begin
      for (int l = 0; l < NUM_J; l++) begin
        trial[k][l] = RW'(dn_r[k-1 < 0 ? 0 : k-1][l]) << (QB - k);
        take[k][l]  = (k != 0) && (rem_r[k-1 < 0 ? 0 : k-1][l] >= trial[k][l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < NUM_J; l++) begin
        rem_r[0][l] <= RW'(mag[l]);
        q_r[0][l]   <= '0;
        dn_r[0][l]  <= s6_den_r[l];
        neg_r[0][l] <= s6_num_r[l][NW-1];
        ovf_r[0][l] <= RW'(mag[l]) >= (RW'(s6_den_r[l]) << QB);
      end
      z0_r[0] <= s6_z0_r;
      for (int k = 1; k <= QB; k++) begin
        for (int l = 0; l < NUM_J; l++) begin
          rem_r[k][l] <= take[k][l] ? rem_r[k-1][l] - trial[k][l] : rem_r[k-1][l];
          q_r[k][l]   <= q_r[k-1][l] | (take[k][l] ? (QB'(1) << (QB - k)) : '0);
          dn_r[k][l]  <= dn_r[k-1][l];
          neg_r[k][l] <= neg_r[k-1][l];
          ovf_r[k][l] <= ovf_r[k-1][l];
        end
        z0_r[k] <= z0_r[k-1];
      end
    end
  end

  // Final stage: round to nearest, saturate and apply the sign.
  logic [QB:0]  qf  [NUM_J];
  logic [QB:0]  lim [NUM_J];
  logic [QB-1:0] res [NUM_J];
  logic [QB:0]  mg  [NUM_J];

  always_comb begin
    for (int l = 0; l < NUM_J; l++) begin
      qf[l]  = {1'b0, q_r[QB][l]} +
               (({1'b0, rem_r[QB][l]} >= ((RW+1)'(dn_r[QB][l]) >> 1) + (RW+1)'(0) &&
                 ({rem_r[QB][l], 1'b0} >= (RW+1)'(dn_r[QB][l]))) ? (QB+1)'(1) : '0);
      lim[l] = neg_r[QB][l] ? (QB+1)'(33'h0_8000_0000) : (QB+1)'(33'h0_7FFF_FFFF);
      mg[l]  = (ovf_r[QB][l] || (qf[l] > lim[l])) ? lim[l] : qf[l];
      res[l] = neg_r[QB][l] ? QB'(-mg[l]) : QB'(mg[l]);
    end
  end

  logic [QB-1:0] j_r [NUM_J];
  logic          dinv_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < NUM_J; l++) begin
        j_r[l] <= res[l];
      end
      dinv_r <= z0_r[QB];
    end
  end

  assign out_ch.valid         = vld_r[NST-1];
  assign out_ch.j_0           = j_r[0];
  assign out_ch.j_1           = j_r[1];
  assign out_ch.j_2           = j_r[2];
  assign out_ch.j_3           = j_r[3];
  assign out_ch.j_4           = j_r[4];
  assign out_ch.j_5           = j_r[5];
  assign out_ch.depth_invalid = dinv_r;

`ifndef SYNTH
  // A zero depth must give saturated translation entries.
  a_zero_depth_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.depth_invalid) |->
      ((out_ch.j_3 == 32'sh7FFF_FFFF || out_ch.j_3 == 32'sh8000_0000) &&
       (out_ch.j_4 == 32'sh7FFF_FFFF || out_ch.j_4 == 32'sh8000_0000)))
    else $error("zero depth result not saturated");

  // A stalled output freezes every stage's valid bit.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NST-1] && !out_ch.ready) |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  // Input is refused exactly when the output stalls.
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == !(vld_r[NST-1] && !out_ch.ready))
    else $error("input ready does not follow output stall");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import pjr_pkg::*;

  localparam int unsigned LATENCY   = 40;
  localparam int unsigned MAX_CYCLE = 600000;

  // One point with its gradient, and one Jacobian row.
  typedef struct {
    word_t px, py, pz, gx, gy;
  } point_t;

  typedef struct {
    word_t j [NUM_J];
    logic  dinv;
  } jrow_t;

  logic clk;
  logic rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  pjr_in_if  in_ch ();
  pjr_out_if out_ch ();

  photometric_jacobian_row u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Mirror of the configuration registers.
  logic [30:0] focal_x_q, focal_y_q, scale_q;
  word_t       cen_x_q, cen_y_q, cen_z_q;

  jrow_t  rows_pending [$];
  int     err_cnt;
  int     sent_cnt;
  int     recv_cnt;
  int     cycle_cnt;
  bit     send_idle_en;
  bit     recv_idle_en;
  int     recv_wait;
  int     recv_hold;

  // Clock and the run limit.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("timeout at %0t", $time);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Rounded division of exact values, ties away from zero, saturated to 32 bits.
  function automatic word_t div_round_sat(logic signed [159:0] num, logic signed [159:0] den);
    logic        neg;
    logic [159:0] mag, q, lim;
    neg = num < 0;
    mag = neg ? -num : num;
    lim = neg ? 160'h8000_0000 : 160'h7FFF_FFFF;
    if (den == 0) q = lim;
    else q = (2 * mag + den) / (2 * den);
    if (q > lim) q = lim;
    if (neg) q = -q;
    return q[31:0];
  endfunction

  // Expected Jacobian row for one point under the current configuration.
  function automatic jrow_t predict_jacobian(point_t p);
    logic signed [159:0] x, y, z, gx, gy, c1, c2, c3, s, u, v, a, b, g;
    logic signed [159:0] dx1, dy2, dz3, az, z2, n;
    jrow_t r;
    x = p.px; y = p.py; z = p.pz; gx = p.gx; gy = p.gy;
    c1 = cen_x_q; c2 = cen_y_q; c3 = cen_z_q;
    s = (scale_q == 0) ? 1 : $signed({129'd0, scale_q});
    u = ($signed({129'd0, focal_x_q}) * gx) >>> 16;
    v = ($signed({129'd0, focal_y_q}) * gy) >>> 16;
    if (u > 160'sh7FFF_FFFF) u = 160'sh7FFF_FFFF;
    if (u < -160'sh8000_0000) u = -160'sh8000_0000;
    if (v > 160'sh7FFF_FFFF) v = 160'sh7FFF_FFFF;
    if (v < -160'sh8000_0000) v = -160'sh8000_0000;
    a = x * u;
    b = y * v;
    g = (a + b) >>> 16;
    dx1 = x - c1; dy2 = y - c2; dz3 = z - c3;
    az = (z < 0) ? -z : z;
    z2 = z * z;
    n = -((v * z * dz3) + ((g * dy2) <<< 16));
    r.j[0] = div_round_sat(n, z2);
    n = (u * z * dz3) + ((g * dx1) <<< 16);
    r.j[1] = div_round_sat(n, z2);
    n = v * dx1 - u * dy2;
    r.j[2] = div_round_sat((z < 0) ? -n : n, az);
    n = u <<< 32;
    r.j[3] = div_round_sat((z < 0) ? -n : n, az * s);
    n = v <<< 32;
    r.j[4] = div_round_sat((z < 0) ? -n : n, az * s);
    n = -(g <<< 48);
    r.j[5] = div_round_sat(n, z2 * s);
    r.dinv = (z == 0);
    return r;
  endfunction

  // Receiver ready, driven on the falling edge.
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      out_ch.ready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else if (recv_wait > 0) begin
      out_ch.ready <= 1'b0;
      recv_wait <= recv_wait - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Result checker: each accepted transaction against the oldest expected row.
  always @(posedge clk) begin
    jrow_t exp_row;
    word_t got [NUM_J];
    if (rst_n && out_ch.valid && out_ch.ready) begin
      recv_cnt = recv_cnt + 1;
      got[0] = out_ch.j_0; got[1] = out_ch.j_1; got[2] = out_ch.j_2;
      got[3] = out_ch.j_3; got[4] = out_ch.j_4; got[5] = out_ch.j_5;
      if (rows_pending.size() == 0) begin
        $display("%0t: unexpected result transaction", $time);
        err_cnt = err_cnt + 1;
      end else begin
        exp_row = rows_pending.pop_front();
        for (int k = 0; k < NUM_J; k++) begin
          if (got[k] !== exp_row.j[k]) begin
            $display("%0t: j_%0d expected %h actual %h", $time, k, exp_row.j[k], got[k]);
            err_cnt = err_cnt + 1;
          end
        end
        if (out_ch.depth_invalid !== exp_row.dinv) begin
          $display("%0t: depth_invalid expected %b actual %b", $time, exp_row.dinv,
                   out_ch.depth_invalid);
          err_cnt = err_cnt + 1;
        end
      end
      recv_wait = recv_idle_en ? $urandom_range(0, 9) : 0;
    end
  end

  // Register write: setup cycle, then access cycle.
  task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_FOCAL_X:  focal_x_q = val[30:0];
      REG_FOCAL_Y:  focal_y_q = val[30:0];
      REG_CENTER_X: cen_x_q   = val;
      REG_CENTER_Y: cen_y_q   = val;
      REG_CENTER_Z: cen_z_q   = val;
      REG_SCALE_S:  scale_q   = val[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic cfg_all(logic [31:0] fx, logic [31:0] fy, logic [31:0] cx,
                         logic [31:0] cy, logic [31:0] cz, logic [31:0] sc);
    cfg_write(REG_FOCAL_X, fx);
    cfg_write(REG_FOCAL_Y, fy);
    cfg_write(REG_CENTER_X, cx);
    cfg_write(REG_CENTER_Y, cy);
    cfg_write(REG_CENTER_Z, cz);
    cfg_write(REG_SCALE_S, sc);
  endtask

  // Send one point; the expected row is queued at acceptance.
  task automatic send_point(point_t p);
    int gap;
    gap = send_idle_en ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.point_x = p.px;
    in_ch.point_y = p.py;
    in_ch.point_z = p.pz;
    in_ch.grad_x  = p.gx;
    in_ch.grad_y  = p.gy;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    rows_pending.push_back(predict_jacobian(p));
    sent_cnt = sent_cnt + 1;
  endtask

  // Drop valid and wait until every expected row has come back.
  task automatic drain_pipe();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (rows_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      3: return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
      4: return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.px = rand_word();
    p.py = rand_word();
    p.gx = rand_word();
    p.gy = rand_word();
    if ($urandom_range(0, 24) == 0) p.pz = 0;
    else if ($urandom_range(0, 2) == 0) p.pz = $urandom;
    else p.pz = $signed($urandom_range(32'h0000_4000, 32'h0040_0000))
                * (($urandom_range(0, 5) == 0) ? -1 : 1);
    return p;
  endfunction

  function automatic point_t mk_point(word_t x, word_t y, word_t z, word_t gx, word_t gy);
    point_t p;
    p.px = x; p.py = y; p.pz = z; p.gx = gx; p.gy = gy;
    return p;
  endfunction

  // Directed points at reset values and at register extremes: zero depth, negative depth, field extremes.
  task automatic test_directed();
    word_t mx, mn;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    send_idle_en = 1'b1;
    send_point(mk_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0004_0000, 32'sh0000_8000,
                        -32'sh0000_4000));
    send_point(mk_point(32'sh0001_0000, -32'sh0001_0000, 0, 32'sh0001_0000, 32'sh0001_0000));
    send_point(mk_point(0, 0, 0, 0, 0));
    send_point(mk_point(-32'sh0001_0000, 32'sh0001_0000, 0, -32'sh0001_0000, 0));
    send_point(mk_point(32'sh0003_0000, 32'sh0001_8000, -32'sh0002_0000, 32'sh0000_1000,
                        32'sh0000_2000));
    send_point(mk_point(mx, mx, mx, mx, mx));
    send_point(mk_point(mn, mn, mn, mn, mn));
    send_point(mk_point(mx, mn, 1, mx, mn));
    send_point(mk_point(mn, mx, -1, mn, mx));
    send_point(mk_point(0, 0, 32'sh0001_0000, 0, 0));
    send_point(mk_point(32'sh0000_0001, -32'sh0000_0001, 32'sh0001_0000, 1, -1));
    send_point(mk_point(-1, -1, -1, -1, -1));
    drain_pipe();
    // Register extremes, including a zero scale, which acts as the smallest nonzero code.
    cfg_all(32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0);
    send_point(mk_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000, 32'sh0000_0100,
                        32'sh0000_0100));
    send_point(mk_point(mn, mx, mx, 1, 1));
    send_point(mk_point(0, 0, 0, mx, mn));
    drain_pipe();
    cfg_all(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF);
    send_point(mk_point(32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000, 32'sh0000_0100,
                        -32'sh0000_0100));
    send_point(mk_point(mx, mn, mn, mx, mn));
    send_point(mk_point(5, 7, -3, 11, 13));
    drain_pipe();
  endtask

  // Random points over several register settings, with and without idling.
  task automatic test_random(int phases, int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      if (ph % 3 == 0) begin
        cfg_all($urandom_range(32'h0100_0000, 32'h0400_0000),
                $urandom_range(32'h0100_0000, 32'h0400_0000),
                rand_word(), rand_word(), rand_word(),
                $urandom_range(32'h0000_4000, 32'h0004_0000));
      end else begin
        cfg_all($urandom, $urandom, $urandom, $urandom, $urandom,
                ($urandom_range(0, 3) == 0) ? 0 : $urandom);
      end
      send_idle_en = (ph % 4 != 1);
      recv_idle_en = (ph % 4 != 2);
      for (int i = 0; i < per_phase; i++) send_point(rand_point());
      drain_pipe();
    end
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
  endtask

  // Long receiver stall while the sender keeps offering, so the input stalls.
  task automatic test_backpressure();
    send_idle_en = 1'b0;
    recv_hold = 300;
    for (int i = 0; i < 120; i++) send_point(rand_point());
    drain_pipe();
    send_idle_en = 1'b1;
  endtask

  initial begin
    rst_n        = 1'b0;
    cycle_cnt    = 0;
    err_cnt      = 0;
    sent_cnt     = 0;
    recv_cnt     = 0;
    recv_wait    = 0;
    recv_hold    = 0;
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    in_ch.valid   = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    in_ch.grad_x  = '0;
    in_ch.grad_y  = '0;
    out_ch.ready  = 1'b0;
    focal_x_q = 31'd33554432;
    focal_y_q = 31'd33554432;
    cen_x_q   = '0;
    cen_y_q   = '0;
    cen_z_q   = '0;
    scale_q   = 31'd65536;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_backpressure();
    test_random(12, 150);

    drain_pipe();
    $display("Sent %0d points and checked %0d Jacobian rows over directed extremes,",
             sent_cnt, recv_cnt);
    $display("random register settings, zero depth, and receiver and sender stalls.");
    if (err_cnt == 0 && rows_pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
